// ===== hw/rtl/lacc_pkg.sv =====
package lacc_pkg;

  localparam int NCH = 3;
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] REG_ALBEDO_RED = 8'd0;
  localparam logic [7:0] REG_ALBEDO_GREEN = 8'd1;
  localparam logic [7:0] REG_ALBEDO_BLUE = 8'd2;
  localparam logic [7:0] REG_FUZZ_GAIN = 8'd3;

  localparam logic [15:0] ALBEDO_RED_RST = 16'd0;
  localparam logic [15:0] ALBEDO_GREEN_RST = 16'd38550;
  localparam logic [15:0] ALBEDO_BLUE_RST = 16'd42205;
  localparam logic [16:0] FUZZ_RST = 17'd19661;
  localparam logic [16:0] FUZZ_ONE = 17'd65536;

  localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
  localparam logic [15:0] OUT_MAX = 16'hFFFF;

  typedef logic [NCH-1:0][15:0] rgb16_t;
  typedef logic [NCH-1:0][31:0] rgb32_t;

  typedef struct packed {
    logic   amb;
    logic   last;
    rgb16_t inten;
    rgb32_t ifz;
    logic [31:0] dotp;
  } entry_t;

endpackage

// ===== hw/rtl/lacc_front.sv =====
module lacc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              ambient_on,
  input  logic              diffuse_on,
  input  logic [15:0]       intensity_red,
  input  logic [15:0]       intensity_green,
  input  logic [15:0]       intensity_blue,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic              last_light,
  input  logic [16:0]       fuzz_gain,
  output logic              push,
  output lacc_pkg::entry_t  push_entry,
  input  logic              q_full
);
  import lacc_pkg::*;

  logic        f_valid;
  logic        f_amb, f_dif, f_last;
  rgb16_t      f_inten;
  rgb32_t      f_ifz;
  logic signed [31:0] f_dp0, f_dp1, f_dp2;

  logic        in_fire;
  logic [16:0] fz;
  rgb16_t      inten_in;
  logic [31:0] ifz_full [NCH];
  logic signed [33:0] dot;

  assign in_stall = f_valid && q_full;
  assign in_fire  = in_valid && !in_stall;
  assign push     = f_valid && !q_full;

  assign fz = (fuzz_gain > FUZZ_ONE) ? FUZZ_ONE : fuzz_gain;
  assign inten_in = {intensity_blue, intensity_green, intensity_red};

  // intensity times clamped fuzz stays below 2^32
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ifz_full[c] = {16'd0, inten_in[c]} * {15'd0, fz};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_fire) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_amb   <= ambient_on;
      f_dif   <= diffuse_on;
      f_last  <= last_light;
      f_inten <= inten_in;
      for (int c = 0; c < NCH; c++) begin
        f_ifz[c] <= ifz_full[c];
      end
      f_dp0 <= dir_x * normal_x;
      f_dp1 <= dir_y * normal_y;
      f_dp2 <= dir_z * normal_z;
    end
  end

  // dot of up to three Q1.14 products; positive max 3*2^30 fits 32 bits
  assign dot = 34'(f_dp0) + 34'(f_dp1) + 34'(f_dp2);

  always_comb begin
    push_entry.amb   = f_amb;
    push_entry.last  = f_last;
    push_entry.inten = f_inten;
    push_entry.ifz   = f_ifz;
    push_entry.dotp  = (f_dif && dot > 34'sd0) ? dot[31:0] : 32'd0;
  end

endmodule

// ===== hw/rtl/lacc_queue.sv =====
module lacc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lacc_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output lacc_pkg::entry_t pop_entry,
  output logic             empty
);
  import lacc_pkg::*;

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign full      = (count == (QAW+1)'(QDEPTH));
  assign empty     = (count == '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/lacc_back.sv =====
module lacc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  lacc_pkg::entry_t q_entry,
  output logic             pop,
  input  lacc_pkg::rgb16_t albedo,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      color_red,
  output logic [15:0]      color_green,
  output logic [15:0]      color_blue
);
  import lacc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  state, state_next;
  logic        at_start;
  entry_t      w;
  logic [NCH-1:0][19:0] term;
  logic [NCH-1:0][23:0] sum;
  logic [NCH-1:0][23:0] sum_next;
  logic [NCH-1:0][15:0] color;
  logic [NCH-1:0][15:0] color_next;
  logic [63:0] prod [NCH];
  logic [39:0] fin  [NCH];
  logic [25:0] acc  [NCH];
  logic [23:0] base [NCH];
  logic        out_free;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c] = {32'd0, w.ifz[c]} * {32'd0, w.dotp};
      base[c] = at_start ? {12'd0, albedo[c][15:4]} : sum[c];
      acc[c]  = {2'd0, base[c]} + (w.amb ? {10'd0, w.inten[c]} : 26'd0)
              + {6'd0, term[c]};
      sum_next[c] = (acc[c] > {2'd0, SUM_MAX}) ? SUM_MAX : acc[c][23:0];
      fin[c]  = {16'd0, sum[c]} * {24'd0, albedo[c]};
      color_next[c] = (|fin[c][39:32]) ? OUT_MAX : fin[c][31:16];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = w.last ? ST_FIN : ST_IDLE;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      at_start  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ACC) begin
        at_start <= 1'b0;
      end else if (state == ST_FIN && out_free) begin
        at_start <= 1'b1;
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w <= q_entry;
    end
    if (state == ST_MUL) begin
      for (int c = 0; c < NCH; c++) begin
        term[c] <= prod[c][63:44];
      end
    end
    if (state == ST_ACC) begin
      sum <= sum_next;
    end
    if (state == ST_FIN && out_free) begin
      color <= color_next;
    end
  end

  assign color_red   = color[0];
  assign color_green = color[1];
  assign color_blue  = color[2];

endmodule

// ===== hw/rtl/light_accumulate_shader.sv =====
// Path: an accepted last light goes through the input stage, the queue, the
// back sequencer (pop, multiply, accumulate) and the final albedo multiply to
// its color beat; an output stall holds the final state. A new light is popped
// only from idle, after the one before has finished, with its final multiply
// for a point's last light. A 2-entry queue lets the input side run ahead.
// Reset (rst, synchronous): registers return to their reset values, queue and
// output empty, accumulator seeded from the albedo.
module light_accumulate_shader (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_index,
  input  logic [16:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              ambient_on,
  input  logic              diffuse_on,
  input  logic [15:0]       intensity_red,
  input  logic [15:0]       intensity_green,
  input  logic [15:0]       intensity_blue,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic              last_light,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       color_red,
  output logic [15:0]       color_green,
  output logic [15:0]       color_blue
);
  import lacc_pkg::*;

  rgb16_t      albedo;
  logic [16:0] fuzz_gain;
  logic        push, pop, q_full, q_empty;
  entry_t      push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      albedo    <= {ALBEDO_BLUE_RST, ALBEDO_GREEN_RST, ALBEDO_RED_RST};
      fuzz_gain <= FUZZ_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALBEDO_RED:   albedo[0] <= cfg_data[15:0];
        REG_ALBEDO_GREEN: albedo[1] <= cfg_data[15:0];
        REG_ALBEDO_BLUE:  albedo[2] <= cfg_data[15:0];
        REG_FUZZ_GAIN:    fuzz_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  lacc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .ambient_on      (ambient_on),
    .diffuse_on      (diffuse_on),
    .intensity_red   (intensity_red),
    .intensity_green (intensity_green),
    .intensity_blue  (intensity_blue),
    .dir_x           (dir_x),
    .dir_y           (dir_y),
    .dir_z           (dir_z),
    .normal_x        (normal_x),
    .normal_y        (normal_y),
    .normal_z        (normal_z),
    .last_light      (last_light),
    .fuzz_gain       (fuzz_gain),
    .push            (push),
    .push_entry      (push_entry),
    .q_full          (q_full)
  );

  lacc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  lacc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_entry     (pop_entry),
    .pop         (pop),
    .albedo      (albedo),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_red   (color_red),
    .color_green (color_green),
    .color_blue  (color_blue)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import lacc_pkg::*;

  localparam int DRAIN_CYCLES = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int ITEMS_PER_PHASE = 110;
  localparam logic [7:0] REG_NONE = 8'hFF;

  typedef struct packed {
    logic amb;
    logic dif;
    logic last;
    rgb16_t inten;
    logic [2:0][15:0] dir;
    logic [2:0][15:0] nrm;
  } light_t;

  typedef enum bit {ROW_LIGHT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [7:0] idx;
    logic [16:0] val;
    light_t l;
    bit typed;
    rgb16_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [7:0] cfg_index;
  logic [16:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic ambient_on, diffuse_on, last_light;
  logic [15:0] intensity_red, intensity_green, intensity_blue;
  logic [15:0] dir_x, dir_y, dir_z, normal_x, normal_y, normal_z;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] color_red, color_green, color_blue;

  light_accumulate_shader DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .ambient_on, .diffuse_on,
    .intensity_red, .intensity_green, .intensity_blue,
    .dir_x, .dir_y, .dir_z, .normal_x, .normal_y, .normal_z, .last_light,
    .out_valid, .out_stall, .color_red, .color_green, .color_blue
  );

  always #5 clk = ~clk;

  // shading state mirrored from the block
  logic [15:0] surf_albedo [NCH];
  logic [16:0] fuzz_reg;
  logic [23:0] acc_rgb [NCH];
  bit fresh_point;

  rgb16_t pending_colors [$];
  int unsigned mismatches = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  string chan_name [NCH] = '{"red", "green", "blue"};

  function automatic void reseed();
    for (int ch = 0; ch < NCH; ch++) acc_rgb[ch] = 24'(surf_albedo[ch] >> 4);
  endfunction

  function automatic void apply_reg(input logic [7:0] idx, input logic [16:0] val);
    case (idx)
      REG_ALBEDO_RED: surf_albedo[0] = val[15:0];
      REG_ALBEDO_GREEN: surf_albedo[1] = val[15:0];
      REG_ALBEDO_BLUE: surf_albedo[2] = val[15:0];
      REG_FUZZ_GAIN: fuzz_reg = val;
      default: return;
    endcase
    if (idx != REG_FUZZ_GAIN && fresh_point) reseed();
  endfunction

  function automatic void accumulate_light(input light_t l, output bit emit,
                                           output rgb16_t col);
    longint dotp;
    logic [16:0] fz;
    logic [65:0] prod;
    logic [24:0] s;
    logic [39:0] p;
    dotp = 0;
    for (int k = 0; k < 3; k++)
      dotp += longint'($signed(l.dir[k])) * longint'($signed(l.nrm[k]));
    fz = (fuzz_reg > FUZZ_ONE) ? FUZZ_ONE : fuzz_reg;
    fresh_point = 1'b0;
    col = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      if (l.amb) begin
        s = {1'b0, acc_rgb[ch]} + 25'(l.inten[ch]);
        acc_rgb[ch] = s[24] ? SUM_MAX : s[23:0];
      end
      if (l.dif && dotp > 0) begin
        prod = 66'(l.inten[ch]) * 66'(fz) * 66'(dotp);
        s = {1'b0, acc_rgb[ch]} + 25'(prod >> 44);
        acc_rgb[ch] = s[24] ? SUM_MAX : s[23:0];
      end
    end
    emit = l.last;
    if (l.last) begin
      for (int ch = 0; ch < NCH; ch++) begin
        p = (40'(acc_rgb[ch]) * 40'(surf_albedo[ch])) >> 16;
        col[ch] = (p > 40'(OUT_MAX)) ? OUT_MAX : p[15:0];
      end
      reseed();
      fresh_point = 1'b1;
    end
  endfunction

  function automatic light_t mk(logic amb, logic dif, logic last,
                                logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                                logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    return '{amb, dif, last, {b, g, r}, {dz, dy, dx}, {nz, ny, nx}};
  endfunction

  function automatic row_t cfg_row(logic [7:0] idx, logic [16:0] val);
    return '{ROW_CFG, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic row_t lit_row(light_t l, bit typed = 1'b0, rgb16_t want = '0);
    return '{ROW_LIGHT, 8'd0, 17'd0, l, typed, want};
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'($urandom());
      1: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h4000;
          3: return 16'hC000;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rand_inten();
    return ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(8191));
  endfunction

  function automatic light_t rand_light(bit last, bit no_light);
    light_t l;
    l.amb = no_light ? 1'b0 : 1'($urandom_range(1));
    l.dif = no_light ? 1'b0 : ($urandom_range(3) != 0);
    l.last = last;
    for (int ch = 0; ch < NCH; ch++) l.inten[ch] = rand_inten();
    for (int k = 0; k < 3; k++) begin
      l.dir[k] = rand_axis();
      l.nrm[k] = rand_axis();
    end
    return l;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_colors.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [16:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_light(input light_t l, input bit typed = 1'b0,
                            input rgb16_t want = '0);
    bit emit;
    rgb16_t col;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ambient_on <= l.amb;
    diffuse_on <= l.dif;
    last_light <= l.last;
    intensity_red <= l.inten[0];
    intensity_green <= l.inten[1];
    intensity_blue <= l.inten[2];
    dir_x <= l.dir[0];
    dir_y <= l.dir[1];
    dir_z <= l.dir[2];
    normal_x <= l.nrm[0];
    normal_y <= l.nrm[1];
    normal_z <= l.nrm[2];
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    accumulate_light(l, emit, col);
    if (emit) pending_colors.push_back(typed ? want : col);
  endtask

  // receiver: random stall, plus one long hold so the input side backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rgb16_t got;
    rgb16_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {color_blue, color_green, color_red};
      if (pending_colors.size() == 0) begin
        flag_mismatch("unexpected color beat, red", got[0], 0);
      end else begin
        want = pending_colors.pop_front();
        for (int ch = 0; ch < NCH; ch++)
          if (got[ch] !== want[ch])
            flag_mismatch({"color_", chan_name[ch]}, got[ch], want[ch]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t directed_steps [$];
    int unsigned sent;
    int unsigned n_lights;
    bit no_light;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    ambient_on <= 1'b0;
    diffuse_on <= 1'b0;
    last_light <= 1'b0;
    intensity_red <= '0;
    intensity_green <= '0;
    intensity_blue <= '0;
    dir_x <= '0;
    dir_y <= '0;
    dir_z <= '0;
    normal_x <= '0;
    normal_y <= '0;
    normal_z <= '0;
    surf_albedo[0] = ALBEDO_RED_RST;
    surf_albedo[1] = ALBEDO_GREEN_RST;
    surf_albedo[2] = ALBEDO_BLUE_RST;
    fuzz_reg = FUZZ_RST;
    reseed();
    fresh_point = 1'b1;

    // zero lights straight out of reset
    directed_steps.push_back(lit_row(mk(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, {16'd1698, 16'd1417, 16'd0}));
    directed_steps.push_back(lit_row(mk(1, 1, 0, 16'h1000, 16'h0800, 16'h0400,
                                        16'h4000, 0, 0, 16'h4000, 0, 0)));
    directed_steps.push_back(lit_row(mk(0, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'd11585, 16'd11585, 0, 16'd11585, 16'd11585, 0)));
    directed_steps.push_back(cfg_row(REG_FUZZ_GAIN, FUZZ_ONE));
    // out-of-range vectors, green and blue color outputs saturate
    directed_steps.push_back(lit_row(mk(0, 1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'h8000, 16'h8000, 16'h8000,
                                        16'h8000, 16'h8000, 16'h8000)));
    directed_steps.push_back(lit_row(mk(0, 1, 1, 16'h1234, 16'h2345, 16'h3456,
                                        16'h4000, 0, 0, 16'hC000, 0, 0)));
    directed_steps.push_back(cfg_row(REG_ALBEDO_RED, 17'h0FFFF));
    directed_steps.push_back(cfg_row(REG_ALBEDO_GREEN, 17'h0FFFF));
    directed_steps.push_back(cfg_row(REG_ALBEDO_BLUE, 17'h0FFFF));
    directed_steps.push_back(lit_row(mk(1, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        0, 0, 0, 0, 0, 0),
                                     1'b1, {OUT_MAX, OUT_MAX, OUT_MAX}));
    // fuzz above one
    directed_steps.push_back(cfg_row(REG_FUZZ_GAIN, 17'h1FFFF));
    directed_steps.push_back(lit_row(mk(0, 1, 0, 16'h2000, 16'h3000, 16'h4000,
                                        0, 16'h4000, 0, 0, 16'h4000, 0)));
    directed_steps.push_back(lit_row(mk(1, 1, 0, 16'h7FFF, 16'h0000, 16'h0001,
                                        0, 0, 0, 16'h4000, 16'h4000, 16'h4000)));
    directed_steps.push_back(lit_row(mk(0, 1, 0, 16'h0FFF, 16'h0FFF, 16'h0FFF,
                                        0, 0, 16'hC000, 0, 0, 16'h4000)));
    // albedo change after the point has started: seed kept
    directed_steps.push_back(cfg_row(REG_ALBEDO_RED, 17'd12345));
    directed_steps.push_back(lit_row(mk(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    directed_steps.push_back(cfg_row(REG_FUZZ_GAIN, 17'd0));
    directed_steps.push_back(lit_row(mk(1, 1, 1, 16'h0100, 16'h0200, 16'h0300,
                                        16'h4000, 16'h4000, 16'h4000,
                                        16'h4000, 16'h4000, 16'h4000)));
    directed_steps.push_back(cfg_row(REG_FUZZ_GAIN, 17'd40000));
    directed_steps.push_back(cfg_row(REG_NONE, 17'h1FFFF));
    directed_steps.push_back(cfg_row(REG_ALBEDO_GREEN, 17'h10000));
    directed_steps.push_back(lit_row(mk(1, 1, 0, 16'hFFFF, 16'h8000, 16'h0001,
                                        16'h7FFF, 16'h8000, 16'h7FFF,
                                        16'h7FFF, 16'h8000, 16'h7FFF)));
    directed_steps.push_back(lit_row(mk(0, 1, 1, 16'h0F00, 16'h0F00, 16'h0F00,
                                        16'h4000, 16'h4000, 0, 16'h2000, 16'h2000, 0)));
    directed_steps.push_back(cfg_row(REG_ALBEDO_RED, 17'd0));
    directed_steps.push_back(cfg_row(REG_ALBEDO_GREEN, 17'd0));
    directed_steps.push_back(cfg_row(REG_ALBEDO_BLUE, 17'd0));
    directed_steps.push_back(lit_row(mk(1, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'h4000, 0, 0, 16'h4000, 0, 0),
                                     1'b1, '0));
    directed_steps.push_back(lit_row(mk(1, 0, 0, 16'h0800, 16'h0800, 16'h0800,
                                        0, 0, 0, 0, 0, 0)));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_CFG)
        write_reg(directed_steps[i].idx, directed_steps[i].val);
      else
        send_light(directed_steps[i].l, directed_steps[i].typed, directed_steps[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_ALBEDO_RED, (ph == 1) ? 17'h0FFFF : 17'($urandom()));
      write_reg(REG_ALBEDO_GREEN, (ph == 1) ? 17'h10000 : 17'($urandom()));
      write_reg(REG_ALBEDO_BLUE, 17'($urandom()));
      case (ph)
        0: write_reg(REG_FUZZ_GAIN, 17'($urandom_range(131071)));
        1: write_reg(REG_FUZZ_GAIN, FUZZ_ONE);
        2: write_reg(REG_FUZZ_GAIN, 17'd0);
        default: write_reg(REG_FUZZ_GAIN, 17'h1FFFF);
      endcase
      case (ph)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 58; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 58; end
        default: begin gap_pct = 18; stall_pct = 18; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        no_light = ($urandom_range(9) == 0);
        n_lights = no_light ? 1 : $urandom_range(1, 6);
        for (int k = 0; k < n_lights; k++) begin
          send_light(rand_light(k == n_lights - 1, no_light));
          sent++;
        end
        if (ph == 0 && sent >= 40) hold_req = 1'b1;
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
